// ----- hw/rtl/linear_probe_hash_table_defines.svh -----
// ----------------------------------------------------------------------------
// Linear probe hash table assertion macros
// Concurrent assertion helpers; they compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef LINEAR_PROBE_HASH_TABLE_DEFINES_SVH
`define LINEAR_PROBE_HASH_TABLE_DEFINES_SVH

`ifndef SYNTHESIS
`define LPHT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define LPHT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define LPHT_ASSERT(label, prop, msg)
`define LPHT_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

// ----- hw/rtl/lpht_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear probe hash table package
// Slot, status and operation codes, the FNV-1a offset basis and controller states.
// ----------------------------------------------------------------------------
package lpht_pkg;

  localparam logic [1:0] SLOT_EMPTY = 2'd0;
  localparam logic [1:0] SLOT_USED  = 2'd1;
  localparam logic [1:0] SLOT_TOMB  = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam logic [1:0] MODE_SET = 2'd0;
  localparam logic [1:0] MODE_GET = 2'd1;
  localparam logic [1:0] MODE_DEL = 2'd2;

  localparam logic [63:0] FNV_BASIS = 64'hCBF29CE484222325;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_MOD,
    S_READ,
    S_CHECK,
    S_RESP
  } fsm_e;

endpackage

// ----- hw/rtl/linear_probe_hash_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear probe hash table
// Open-addressing key/value table, FNV-1a hash, linear probing, tombstones.
// ----------------------------------------------------------------------------
// Sequence: accept, hash the key one byte at a time, reduce the hash modulo
//   CAPACITY four bits at a time, read and check each probed slot, respond;
//   get/delete on an empty table and unknown modes go straight to the response.
// Throughput: one transaction at a time; the next is taken once the result
//   has moved to the output register.
// Reset: all slot states are cleared to empty; no transaction is taken meanwhile.
`include "linear_probe_hash_table_defines.svh"

module linear_probe_hash_table import lpht_pkg::*; #(
  parameter int CAPACITY   = 64,
  parameter int VALUE_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [95:0] s_axis_tdata_i,   // [63:0] key, [95:64] write_value
  input  logic [1:0]  s_axis_tuser_i,   // [1:0] mode
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [31:0] read_value
  output logic [2:0]  m_axis_tuser_o    // [1:0] status, [2] was_new
);

  localparam int IDXW = $clog2(CAPACITY);
  localparam int UCW  = $clog2(CAPACITY + 1);
  localparam logic [IDXW-1:0] LAST_IDX = IDXW'(CAPACITY - 1);
  localparam logic [IDXW:0]   CAP_EXT  = (IDXW + 1)'(CAPACITY);

  fsm_e state_q, state_d;

  logic [1:0]            mode_q;
  logic [63:0]           key_q;
  logic [31:0]           wv_q;
  logic [63:0]           h_q;
  logic [3:0]            cnt_q;
  logic [IDXW-1:0]       idx_q, n_q, clr_q, tomb_idx_q;
  logic                  tomb_vld_q;
  logic [UCW-1:0]        used_q;
  logic [1:0]            res_status_q;
  logic                  res_new_q;
  logic [31:0]           res_val_q;

  logic [1:0]            st_mem [CAPACITY];
  logic [63:0]           key_mem [CAPACITY];
  logic [VALUE_BITS-1:0] val_mem [CAPACITY];
  logic [1:0]            st_rd_q;
  logic [63:0]           key_rd_q;
  logic [VALUE_BITS-1:0] val_rd_q;

  logic                  st_we, key_we, val_we, used_inc;
  logic [IDXW-1:0]       wr_addr;
  logic [1:0]            st_wdata;
  logic [1:0]            res_status_d;
  logic                  res_new_d;
  logic [31:0]           res_val_d;

  logic                  s_acc;
  logic [63:0]           hx, h_next;
  logic [IDXW-1:0]       r_next;
  logic [IDXW:0]         r_t;

  logic                  hit, is_empty, is_tomb, walk_last, tomb_any;
  logic [IDXW-1:0]       tomb_addr, idx_inc;
  logic [VALUE_BITS+31:0] wv_ext, rv_ext;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign s_acc = s_axis_tvalid_i && s_axis_tready_o;

  // FNV-1a step: multiply by 2^40 + 0x1B3 as shifts and adds
  assign hx = h_q ^ {56'd0, key_q[8*cnt_q[2:0] +: 8]};
  assign h_next = (hx << 40) + (hx << 8) + (hx << 7) + (hx << 5) + (hx << 4)
                + (hx << 1) + hx;

  // four restoring modulo steps, hash consumed msb first
  always_comb begin
    r_t    = '0;
    r_next = idx_q;
    for (int i = 0; i < 4; i++) begin
      r_t = {r_next, h_q[63-i]};
      if (r_t >= CAP_EXT) begin
        r_t = r_t - CAP_EXT;
      end
      r_next = r_t[IDXW-1:0];
    end
  end

  assign hit       = (st_rd_q == SLOT_USED) && (key_rd_q == key_q);
  assign is_empty  = (st_rd_q == SLOT_EMPTY);
  assign is_tomb   = (st_rd_q == SLOT_TOMB);
  assign walk_last = (n_q == LAST_IDX);
  assign tomb_any  = tomb_vld_q || is_tomb;
  assign tomb_addr = tomb_vld_q ? tomb_idx_q : idx_q;
  assign idx_inc   = (idx_q == LAST_IDX) ? '0 : idx_q + 1'b1;
  assign wv_ext    = {{VALUE_BITS{1'b0}}, wv_q};
  assign rv_ext    = {32'd0, val_rd_q};

  always_comb begin
    state_d      = state_q;
    st_we        = 1'b0;
    key_we       = 1'b0;
    val_we       = 1'b0;
    used_inc     = 1'b0;
    wr_addr      = idx_q;
    st_wdata     = SLOT_USED;
    res_status_d = res_status_q;
    res_new_d    = res_new_q;
    res_val_d    = res_val_q;
    unique case (state_q)
      S_CLEAR: begin
        st_we    = 1'b1;
        wr_addr  = clr_q;
        st_wdata = SLOT_EMPTY;
        if (clr_q == LAST_IDX) state_d = S_IDLE;
      end
      S_IDLE: begin
        res_status_d = ST_MISS;
        res_new_d    = 1'b0;
        res_val_d    = '0;
        if (s_acc) begin
          if (s_axis_tuser_i == MODE_SET) begin
            state_d = S_HASH;
          end else if ((s_axis_tuser_i == MODE_GET || s_axis_tuser_i == MODE_DEL)
                       && used_q != '0) begin
            state_d = S_HASH;
          end else begin
            state_d = S_RESP;
          end
        end
      end
      S_HASH: begin
        if (cnt_q == 4'd7) state_d = S_MOD;
      end
      S_MOD: begin
        if (cnt_q == 4'd15) state_d = S_READ;
      end
      S_READ: begin
        state_d = S_CHECK;
      end
      S_CHECK: begin
        if (hit || is_empty || walk_last) begin
          state_d = S_RESP;
          if (mode_q == MODE_SET) begin
            if (hit) begin
              val_we       = 1'b1;
              res_status_d = ST_OK;
            end else if (tomb_any) begin
              st_we        = 1'b1;
              key_we       = 1'b1;
              val_we       = 1'b1;
              wr_addr      = tomb_addr;
              res_status_d = ST_OK;
              res_new_d    = 1'b1;
            end else if (is_empty) begin
              st_we        = 1'b1;
              key_we       = 1'b1;
              val_we       = 1'b1;
              used_inc     = 1'b1;
              res_status_d = ST_OK;
              res_new_d    = 1'b1;
            end else begin
              res_status_d = ST_FULL;
            end
          end else begin
            if (hit) begin
              res_status_d = ST_OK;
              if (mode_q == MODE_GET) begin
                res_val_d = rv_ext[31:0];
              end else begin
                st_we    = 1'b1;
                st_wdata = SLOT_TOMB;
              end
            end else if (is_empty) begin
              res_status_d = ST_MISS;
            end else begin
              res_status_d = ST_FULL;
            end
          end
        end else begin
          state_d = S_READ;
        end
      end
      S_RESP: begin
        if (!m_axis_tvalid_o || m_axis_tready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q           <= '0;
      used_q          <= '0;
      cnt_q           <= '0;
      m_axis_tvalid_o <= 1'b0;
    end else begin
      if (state_q == S_CLEAR) clr_q <= clr_q + 1'b1;
      if (used_inc) used_q <= used_q + 1'b1;
      if (state_q == S_HASH || state_q == S_MOD) begin
        cnt_q <= (state_d == state_q) ? cnt_q + 1'b1 : '0;
      end else begin
        cnt_q <= '0;
      end
      if (state_q == S_RESP && state_d == S_IDLE) begin
        m_axis_tvalid_o <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_axis_tvalid_o <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    res_status_q <= res_status_d;
    res_new_q    <= res_new_d;
    res_val_q    <= res_val_d;
    if (s_acc) begin
      mode_q <= s_axis_tuser_i;
      key_q  <= s_axis_tdata_i[63:0];
      wv_q   <= s_axis_tdata_i[95:64];
      h_q    <= FNV_BASIS;
    end
    if (state_q == S_HASH) begin
      h_q   <= h_next;
      idx_q <= '0;
    end
    if (state_q == S_MOD) begin
      h_q        <= h_q << 4;
      idx_q      <= r_next;
      n_q        <= '0;
      tomb_vld_q <= 1'b0;
    end
    if (state_q == S_CHECK) begin
      idx_q <= idx_inc;
      n_q   <= n_q + 1'b1;
      if (is_tomb && !tomb_vld_q) begin
        tomb_vld_q <= 1'b1;
        tomb_idx_q <= idx_q;
      end
    end
    if (state_q == S_RESP && state_d == S_IDLE) begin
      m_axis_tuser_o <= {res_new_q, res_status_q};
      m_axis_tdata_o <= res_val_q;
    end
  end

  // slot memories: one write port, one registered read port each
  always_ff @(posedge clk_i) begin
    if (st_we) st_mem[wr_addr] <= st_wdata;
    if (key_we) key_mem[wr_addr] <= key_q;
    if (val_we) val_mem[wr_addr] <= wv_ext[VALUE_BITS-1:0];
    st_rd_q  <= st_mem[idx_q];
    key_rd_q <= key_mem[idx_q];
    val_rd_q <= val_mem[idx_q];
  end

  `LPHT_ASSERT_ALWAYS(a_no_accept_in_clear,
    (state_q == S_CLEAR) |-> !s_axis_tready_o, "accept during clear")
  `LPHT_ASSERT(a_used_monotonic,
    (state_q != S_CLEAR) |=> (used_q >= $past(used_q)), "used count fell")
  `LPHT_ASSERT(a_write_in_check,
    (st_we || key_we || val_we) |-> (state_q == S_CHECK || state_q == S_CLEAR), "stray write")
  `LPHT_ASSERT(a_full_not_new,
    (m_axis_tvalid_o && m_axis_tuser_o[1:0] == ST_FULL) |-> !m_axis_tuser_o[2], "full with new")

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear probe hash table testbench
// Drives set/get/delete/unknown-mode transactions with random idling on both
// stream sides; checks every response against a behavioral copy of the table.
// ----------------------------------------------------------------------------
module testbench;
  import lpht_pkg::*;

  localparam int SLOTS      = 64;
  localparam int TABLE_ROWS = 17;
  localparam longint unsigned LIMIT = 4000000;

  typedef struct packed {
    logic [1:0]  mode;
    logic [63:0] key;
    logic [31:0] wval;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        was_new;
    logic [31:0] rval;
  } rsp_t;

  typedef struct packed {
    req_t req;
    logic known;   // expected response typed in the table
    rsp_t rsp;
  } row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [95:0] s_axis_tdata_i;
  logic [1:0]  s_axis_tuser_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [31:0] m_axis_tdata_o;
  logic [2:0]  m_axis_tuser_o;

  linear_probe_hash_table dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i, .s_axis_tready_o, .s_axis_tdata_i, .s_axis_tuser_i,
    .m_axis_tvalid_o, .m_axis_tready_i, .m_axis_tdata_o, .m_axis_tuser_o
  );

  // Table shadow
  logic [1:0]  shadow_state [SLOTS];
  logic [63:0] shadow_key [SLOTS];
  logic [31:0] shadow_val [SLOTS];
  int          shadow_used;
  rsp_t        pending_rsp [$];
  logic [63:0] key_pool [$];
  int          errors;
  longint unsigned cycles = 0;
  int          send_idle_pct;
  int          recv_stall_pct;

  function automatic logic [63:0] fnv1a(logic [63:0] k);
    logic [63:0] h;
    h = 64'hCBF29CE484222325;
    for (int b = 0; b < 8; b++) begin
      h = h ^ {56'd0, k[8*b +: 8]};
      h = h * 64'd1099511628211;
    end
    return h;
  endfunction

  function automatic rsp_t apply_request(req_t r);
    rsp_t o;
    int idx, hit, tomb, hole;
    o = '{status: ST_MISS, was_new: 1'b0, rval: 32'd0};
    hit = -1;
    tomb = -1;
    hole = -1;
    if (r.mode == MODE_SET || ((r.mode == MODE_GET || r.mode == MODE_DEL) && shadow_used != 0))
    begin
      idx = int'(fnv1a(r.key) % SLOTS);
      for (int n = 0; n < SLOTS; n++) begin
        if (shadow_state[idx] == SLOT_EMPTY) begin
          hole = idx;
          break;
        end
        if (shadow_state[idx] == SLOT_TOMB) begin
          if (tomb < 0) tomb = idx;
        end else if (shadow_key[idx] == r.key) begin
          hit = idx;
          break;
        end
        idx = (idx + 1) % SLOTS;
      end
      if (r.mode == MODE_SET) begin
        o.status = ST_OK;
        if (hit >= 0) begin
          shadow_val[hit] = r.wval;
        end else if (tomb >= 0 || hole >= 0) begin
          idx = (tomb >= 0) ? tomb : hole;
          if (tomb < 0) shadow_used++;
          shadow_state[idx] = SLOT_USED;
          shadow_key[idx] = r.key;
          shadow_val[idx] = r.wval;
          o.was_new = 1'b1;
        end else begin
          o.status = ST_FULL;
        end
      end else if (hit >= 0) begin
        o.status = ST_OK;
        if (r.mode == MODE_GET) o.rval = shadow_val[hit];
        else shadow_state[hit] = SLOT_TOMB;
      end else begin
        o.status = (hole >= 0) ? ST_MISS : ST_FULL;
      end
    end
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h, expected %0h at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout at cycle %0d", cycles);
      $display("testbench: done, errors");
      $finish;
    end
  end

  // Response side: random stall and check against oldest expectation
  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (pending_rsp.size() == 0) begin
          report_mismatch("unexpected transaction",
                          {29'd0, m_axis_tuser_o, m_axis_tdata_o}, 64'd0);
        end else begin
          want = pending_rsp.pop_front();
          if (m_axis_tuser_o[1:0] !== want.status)
            report_mismatch("status", 64'(m_axis_tuser_o[1:0]), 64'(want.status));
          if (m_axis_tuser_o[2] !== want.was_new)
            report_mismatch("was_new", 64'(m_axis_tuser_o[2]), 64'(want.was_new));
          if (m_axis_tdata_o !== want.rval)
            report_mismatch("read_value", 64'(m_axis_tdata_o), 64'(want.rval));
        end
      end
      m_axis_tready_i <= ($urandom_range(99) >= recv_stall_pct);
    end else begin
      m_axis_tready_i <= 1'b0;
    end
  end

  // Hold valid from one transaction to the next unless the sender idles
  task automatic send(req_t r, logic known, rsp_t fixed);
    rsp_t o;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= {r.wval, r.key};
    s_axis_tuser_i <= r.mode;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    o = apply_request(r);
    if (known && o !== fixed) report_mismatch("table row", 64'(o), 64'(fixed));
    pending_rsp.push_back(o);
  endtask

  function automatic logic [63:0] pick_key();
    int sel;
    sel = $urandom_range(99);
    if (key_pool.size() != 0 && sel < 60) return key_pool[$urandom_range(key_pool.size() - 1)];
    if (sel < 70) return {56'd0, 8'($urandom_range(255))};
    if (sel < 75) return {$urandom, $urandom} | 64'hFFFF_0000_0000_0000;
    return {$urandom, $urandom};
  endfunction

  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk_i);
  endtask

  row_t directed [TABLE_ROWS];
  req_t r;
  int pick;
  logic [63:0] k;

  initial begin
    errors = 0;
    shadow_used = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    s_axis_tuser_i = MODE_SET;
    for (int i = 0; i < SLOTS; i++) shadow_state[i] = SLOT_EMPTY;

    // Empty-table misses, extremes, overwrite, tombstone reuse, unknown mode
    directed = '{
      '{'{MODE_GET, 64'd0, 32'd0}, 1'b1, '{ST_MISS, 1'b0, 32'd0}},
      '{'{MODE_DEL, '1, 32'd0}, 1'b1, '{ST_MISS, 1'b0, 32'd0}},
      '{'{2'd3, '1, '1}, 1'b1, '{ST_MISS, 1'b0, 32'd0}},
      '{'{MODE_SET, 64'd0, '1}, 1'b1, '{ST_OK, 1'b1, 32'd0}},
      '{'{MODE_GET, 64'd0, 32'd0}, 1'b1, '{ST_OK, 1'b0, '1}},
      '{'{MODE_SET, '1, 32'd0}, 1'b1, '{ST_OK, 1'b1, 32'd0}},
      '{'{MODE_GET, '1, '1}, 1'b1, '{ST_OK, 1'b0, 32'd0}},
      '{'{MODE_SET, 64'd0, 32'h5A5A_A5A5}, 1'b1, '{ST_OK, 1'b0, 32'd0}},
      '{'{MODE_GET, 64'd0, 32'd0}, 1'b0, '0},
      '{'{MODE_GET, 64'h8000_0000_0000_0001, 32'd0}, 1'b0, '0},
      '{'{MODE_DEL, 64'd0, 32'd0}, 1'b1, '{ST_OK, 1'b0, 32'd0}},
      '{'{MODE_GET, 64'd0, 32'd0}, 1'b0, '0},
      '{'{MODE_DEL, 64'd0, 32'd0}, 1'b0, '0},
      '{'{2'd3, 64'd0, 32'd1}, 1'b1, '{ST_MISS, 1'b0, 32'd0}},
      '{'{MODE_SET, 64'd0, 32'd7}, 1'b0, '0},
      '{'{MODE_GET, 64'd0, 32'd0}, 1'b0, '0},
      '{'{MODE_SET, 64'h0123_4567_89AB_CDEF, 32'h8000_0001}, 1'b0, '0}
    };

    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    for (int i = 0; i < TABLE_ROWS; i++)
      send(directed[i].req, directed[i].known, directed[i].rsp);
    drain();

    // Random phases; one of them is weighted toward sets to reach status full
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
        3: begin send_idle_pct = 37; recv_stall_pct = 37; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      for (int i = 0; i < 200; i++) begin
        pick = $urandom_range(99);
        k = pick_key();
        r.key = k;
        r.wval = $urandom;
        if (phase == 4) r.mode = (pick < 55) ? MODE_SET : (pick < 85) ? MODE_GET : MODE_DEL;
        else r.mode = (pick < 40) ? MODE_SET : (pick < 70) ? MODE_GET :
                      (pick < 97) ? MODE_DEL : 2'd3;
        if (r.mode == MODE_SET) key_pool.push_back(k);
        send(r, 1'b0, '0);
      end
      drain();
    end

    repeat (400) @(posedge clk_i);
    if (errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
